// ===== rtl/assert_macros.svh =====
// assertion helpers included by the top-level rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on clk, masked while rst_n is low
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same check, also evaluated during reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/fndir_pkg.sv =====
package fndir_pkg;

  // the largest normalised magnitude sits in [2^29, 2^30), the others below 2^30
  localparam int NORM_BITS    = 30;
  // internal angle fraction bits
  localparam int ZFRAC        = 16;
  localparam int CORDIC_STEPS = 23;
  // sum of two squares of normalised magnitudes, padded to an even width
  localparam int SQ_W         = 62;
  localparam int ROOT_W       = SQ_W / 2;
  localparam int REM_W        = ROOT_W + 4;
  // cordic datapath widths
  localparam int CW           = 36;
  localparam int ZW           = 25;
  localparam int ANGLE_W      = 16;

  localparam logic [ZW-1:0] DEG90  = ZW'(90  << ZFRAC);
  localparam logic [ZW-1:0] DEG180 = ZW'(180 << ZFRAC);

  // atan(2^-i) in degrees, 16 fraction bits
  localparam logic [23:0] ATAN_DEG [CORDIC_STEPS] = '{
    24'd2949120, 24'd1740967, 24'd919879, 24'd466945, 24'd234379, 24'd117304,
    24'd58666, 24'd29335, 24'd14668, 24'd7334, 24'd3667, 24'd1833, 24'd917,
    24'd458, 24'd229, 24'd115, 24'd57, 24'd29, 24'd14, 24'd7, 24'd4, 24'd2, 24'd1
  };

endpackage

// ===== rtl/fndir_if.sv =====
// triangle input channel
interface fndir_in_if #(parameter int COORD_BITS = 16) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] ax;
  logic signed [COORD_BITS-1:0] ay;
  logic signed [COORD_BITS-1:0] az;
  logic signed [COORD_BITS-1:0] bx;
  logic signed [COORD_BITS-1:0] by_coord;
  logic signed [COORD_BITS-1:0] bz;
  logic signed [COORD_BITS-1:0] cx;
  logic signed [COORD_BITS-1:0] cy;
  logic signed [COORD_BITS-1:0] cz;

  modport source (output valid, ax, ay, az, bx, by_coord, bz, cx, cy, cz, input ready);
  modport sink   (input valid, ax, ay, az, bx, by_coord, bz, cx, cy, cz, output ready);
endinterface

// angle result channel
interface fndir_out_if ();
  import fndir_pkg::*;
  logic               valid;
  logic               ready;
  logic [ANGLE_W-1:0] angle_from_x;
  logic [ANGLE_W-1:0] angle_from_y;
  logic               degenerate;

  modport source (output valid, angle_from_x, angle_from_y, degenerate, input ready);
  modport sink   (input valid, angle_from_x, angle_from_y, degenerate, output ready);
endinterface

// ===== rtl/fndir_axis.sv =====
module fndir_axis #(
  parameter int ANGLE_FRAC_BITS = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              in_vld,
  input  logic [fndir_pkg::NORM_BITS-1:0]   in_p,
  input  logic                              in_neg,
  input  logic                              in_degen,
  input  logic [fndir_pkg::SQ_W-1:0]        in_sumsq,
  output logic                              out_vld,
  output logic [fndir_pkg::ANGLE_W-1:0]     out_angle,
  output logic                              out_degen
);
  import fndir_pkg::*;

  localparam int RSH = ZFRAC - ANGLE_FRAC_BITS;

  // square root pipeline, one result bit per stage
  logic              sq_v_r    [0:ROOT_W];
  logic [SQ_W-1:0]   sq_n_r    [0:ROOT_W];
  logic [REM_W-1:0]  sq_rem_r  [0:ROOT_W];
  logic [ROOT_W-1:0] sq_root_r [0:ROOT_W];
  logic [NORM_BITS-1:0] sq_p_r [0:ROOT_W];
  logic              sq_neg_r  [0:ROOT_W];
  logic              sq_dg_r   [0:ROOT_W];

  // cordic pipeline, one rotation per stage
  logic                 c_v_r   [0:CORDIC_STEPS];
  logic signed [CW-1:0] c_x_r   [0:CORDIC_STEPS];
  logic signed [CW-1:0] c_y_r   [0:CORDIC_STEPS];
  logic signed [ZW-1:0] c_z_r   [0:CORDIC_STEPS];
  logic                 c_neg_r [0:CORDIC_STEPS];
  logic                 c_dg_r  [0:CORDIC_STEPS];

  logic                 out_vld_r;
  logic [ANGLE_W-1:0]   out_angle_r;
  logic                 out_degen_r;

  // square root entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r[0] <= 1'b0;
    end else if (en) begin
      sq_v_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_n_r[0]    <= in_sumsq;
      sq_rem_r[0]  <= '0;
      sq_root_r[0] <= '0;
      sq_p_r[0]    <= in_p;
      sq_neg_r[0]  <= in_neg;
      sq_dg_r[0]   <= in_degen;
    end
  end

  for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic             ge;

    // bring down the next bit pair and try the next root bit
    always_comb begin
      rem_sh = {sq_rem_r[k][REM_W-3:0], sq_n_r[k][SQ_W-1-2*k -: 2]};
      trial  = REM_W'({sq_root_r[k], 2'b01});
      ge     = (rem_sh >= trial);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[k+1] <= 1'b0;
      end else if (en) begin
        sq_v_r[k+1] <= sq_v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_n_r[k+1]    <= sq_n_r[k];
        sq_rem_r[k+1]  <= ge ? (rem_sh - trial) : rem_sh;
        sq_root_r[k+1] <= {sq_root_r[k][ROOT_W-2:0], ge};
        sq_p_r[k+1]    <= sq_p_r[k];
        sq_neg_r[k+1]  <= sq_neg_r[k];
        sq_dg_r[k+1]   <= sq_dg_r[k];
      end
    end
  end

  // cordic entry: x = own magnitude, y = root of the others
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r[0] <= 1'b0;
    end else if (en) begin
      c_v_r[0] <= sq_v_r[ROOT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_x_r[0]   <= CW'(sq_p_r[ROOT_W]);
      c_y_r[0]   <= CW'(sq_root_r[ROOT_W]);
      c_z_r[0]   <= '0;
      c_neg_r[0] <= sq_neg_r[ROOT_W];
      c_dg_r[0]  <= sq_dg_r[ROOT_W];
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    localparam logic signed [ZW-1:0] ANG = ZW'(ATAN_DEG[i]);
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;

    // arithmetic shifts round towards minus infinity
    always_comb begin
      xs = c_x_r[i] >>> i;
      ys = c_y_r[i] >>> i;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        c_v_r[i+1] <= 1'b0;
      end else if (en) begin
        c_v_r[i+1] <= c_v_r[i];
      end
    end

    // vectoring rotation towards y = 0, nothing when already zero
    always_ff @(posedge clk) begin
      if (en) begin
        if (c_y_r[i] > 0) begin
          c_x_r[i+1] <= c_x_r[i] + ys;
          c_y_r[i+1] <= c_y_r[i] - xs;
          c_z_r[i+1] <= c_z_r[i] + ANG;
        end else if (c_y_r[i] < 0) begin
          c_x_r[i+1] <= c_x_r[i] - ys;
          c_y_r[i+1] <= c_y_r[i] + xs;
          c_z_r[i+1] <= c_z_r[i] - ANG;
        end else begin
          c_x_r[i+1] <= c_x_r[i];
          c_y_r[i+1] <= c_y_r[i];
          c_z_r[i+1] <= c_z_r[i];
        end
        c_neg_r[i+1] <= c_neg_r[i];
        c_dg_r[i+1]  <= c_dg_r[i];
      end
    end
  end

  // clamp, fold for negative component, round to output format, zero when degenerate
  logic signed [ZW-1:0] z_fin;
  logic [ZW-1:0]        z_clamp;
  logic [ZW-1:0]        z_full;
  logic [ZW:0]          z_rnd;
  logic [ANGLE_W-1:0]   angle_nxt;

  always_comb begin
    z_fin = c_z_r[CORDIC_STEPS];
    if (z_fin < 0) begin
      z_clamp = '0;
    end else if (z_fin > $signed(DEG90)) begin
      z_clamp = DEG90;
    end else begin
      z_clamp = z_fin;
    end
    z_full    = c_neg_r[CORDIC_STEPS] ? (DEG180 - z_clamp) : z_clamp;
    z_rnd     = (ZW+1)'(z_full) + ((ZW+1)'(1) << (RSH - 1));
    angle_nxt = c_dg_r[CORDIC_STEPS] ? '0 : ANGLE_W'(z_rnd >> RSH);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= c_v_r[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_angle_r <= angle_nxt;
      out_degen_r <= c_dg_r[CORDIC_STEPS];
    end
  end

  assign out_vld   = out_vld_r;
  assign out_angle = out_angle_r;
  assign out_degen = out_degen_r;

endmodule

// ===== rtl/face_normal_direction_angles_top.sv =====
// throughput: one triangle per cycle; the whole pipeline holds while a result waits
// the two axis units (31-stage square root, 23-stage cordic) set the depth
// reset: synchronous active-low rst_n empties all stage valid bits
`include "assert_macros.svh"
module face_normal_direction_angles_top #(
  parameter int COORD_BITS      = 16,
  parameter int ANGLE_FRAC_BITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  fndir_in_if.sink    in_ch,
  fndir_out_if.source out_ch
);
  import fndir_pkg::*;

  localparam int EW = COORD_BITS + 1;
  localparam int PW = 2 * COORD_BITS + 2;
  localparam int NW = 2 * COORD_BITS + 3;
  localparam int BLW = $clog2(NW + 1);

  logic en;

  logic out_valid_r;
  logic [ANGLE_W-1:0] out_ax_r;
  logic [ANGLE_W-1:0] out_ay_r;
  logic out_degen_r;

  // whole pipeline advances unless a result waits untaken
  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  // stage 1: edge vectors
  logic v1_r;
  logic signed [EW-1:0] ux_r, uy_r, uz_r, vx_r, vy_r, vz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ux_r <= EW'(in_ch.bx)       - EW'(in_ch.ax);
      uy_r <= EW'(in_ch.by_coord) - EW'(in_ch.ay);
      uz_r <= EW'(in_ch.bz)       - EW'(in_ch.az);
      vx_r <= EW'(in_ch.cx)       - EW'(in_ch.ax);
      vy_r <= EW'(in_ch.cy)       - EW'(in_ch.ay);
      vz_r <= EW'(in_ch.cz)       - EW'(in_ch.az);
    end
  end

  // stage 2: cross product partial products
  logic v2_r;
  logic signed [PW-1:0] p_yz_r, p_zy_r, p_zx_r, p_xz_r, p_xy_r, p_yx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_yz_r <= PW'(uy_r * vz_r);
      p_zy_r <= PW'(uz_r * vy_r);
      p_zx_r <= PW'(uz_r * vx_r);
      p_xz_r <= PW'(ux_r * vz_r);
      p_xy_r <= PW'(ux_r * vy_r);
      p_yx_r <= PW'(uy_r * vx_r);
    end
  end

  // stage 3: normal components
  logic v3_r;
  logic signed [NW-1:0] nx_r, ny_r, nz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nx_r <= NW'(p_yz_r) - NW'(p_zy_r);
      ny_r <= NW'(p_zx_r) - NW'(p_xz_r);
      nz_r <= NW'(p_xy_r) - NW'(p_yx_r);
    end
  end

  // stage 4: magnitudes, signs, largest magnitude
  logic v4_r;
  logic [NW-1:0] mx4_r, my4_r, mz4_r, m4_r;
  logic nx_neg4_r, ny_neg4_r;
  logic [NW-1:0] mx_nxt, my_nxt, mz_nxt, mxy_nxt;

  always_comb begin
    mx_nxt  = nx_r[NW-1] ? NW'(-nx_r) : NW'(nx_r);
    my_nxt  = ny_r[NW-1] ? NW'(-ny_r) : NW'(ny_r);
    mz_nxt  = nz_r[NW-1] ? NW'(-nz_r) : NW'(nz_r);
    mxy_nxt = (my_nxt > mx_nxt) ? my_nxt : mx_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mx4_r     <= mx_nxt;
      my4_r     <= my_nxt;
      mz4_r     <= mz_nxt;
      m4_r      <= (mz_nxt > mxy_nxt) ? mz_nxt : mxy_nxt;
      nx_neg4_r <= nx_r[NW-1];
      ny_neg4_r <= ny_r[NW-1];
    end
  end

  // stage 5: bit length of the largest magnitude
  logic v5_r;
  logic [NW-1:0] mx5_r, my5_r, mz5_r;
  logic [BLW-1:0] bl5_r;
  logic nx_neg5_r, ny_neg5_r, dg5_r;
  logic [BLW-1:0] bl_nxt;

  always_comb begin
    bl_nxt = '0;
    for (int b = 0; b < NW; b++) begin
      if (m4_r[b]) begin
        bl_nxt = BLW'(b + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (en) begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mx5_r     <= mx4_r;
      my5_r     <= my4_r;
      mz5_r     <= mz4_r;
      bl5_r     <= bl_nxt;
      nx_neg5_r <= nx_neg4_r;
      ny_neg5_r <= ny_neg4_r;
      dg5_r     <= (m4_r == '0);
    end
  end

  // stage 6: common normalising shift, largest magnitude into [2^29, 2^30)
  logic v6_r;
  logic [NORM_BITS-1:0] mx6_r, my6_r, mz6_r;
  logic nx_neg6_r, ny_neg6_r, dg6_r;
  logic [NW+NORM_BITS-1:0] shx, shy, shz;

  always_comb begin
    shx = {mx5_r, {NORM_BITS{1'b0}}} >> bl5_r;
    shy = {my5_r, {NORM_BITS{1'b0}}} >> bl5_r;
    shz = {mz5_r, {NORM_BITS{1'b0}}} >> bl5_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else if (en) begin
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mx6_r     <= shx[NORM_BITS-1:0];
      my6_r     <= shy[NORM_BITS-1:0];
      mz6_r     <= shz[NORM_BITS-1:0];
      nx_neg6_r <= nx_neg5_r;
      ny_neg6_r <= ny_neg5_r;
      dg6_r     <= dg5_r;
    end
  end

  // stage 7: squares
  logic v7_r;
  logic [2*NORM_BITS-1:0] sqx_r, sqy_r, sqz_r;
  logic [NORM_BITS-1:0] mx7_r, my7_r;
  logic nx_neg7_r, ny_neg7_r, dg7_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
    end else if (en) begin
      v7_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sqx_r     <= (2*NORM_BITS)'(mx6_r * mx6_r);
      sqy_r     <= (2*NORM_BITS)'(my6_r * my6_r);
      sqz_r     <= (2*NORM_BITS)'(mz6_r * mz6_r);
      mx7_r     <= mx6_r;
      my7_r     <= my6_r;
      nx_neg7_r <= nx_neg6_r;
      ny_neg7_r <= ny_neg6_r;
      dg7_r     <= dg6_r;
    end
  end

  // stage 8: sums of the other two squares per axis
  logic v8_r;
  logic [SQ_W-1:0] sumx_r, sumy_r;
  logic [NORM_BITS-1:0] mx8_r, my8_r;
  logic nx_neg8_r, ny_neg8_r, dg8_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v8_r <= 1'b0;
    end else if (en) begin
      v8_r <= v7_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sumx_r    <= SQ_W'(sqy_r) + SQ_W'(sqz_r);
      sumy_r    <= SQ_W'(sqx_r) + SQ_W'(sqz_r);
      mx8_r     <= mx7_r;
      my8_r     <= my7_r;
      nx_neg8_r <= nx_neg7_r;
      ny_neg8_r <= ny_neg7_r;
      dg8_r     <= dg7_r;
    end
  end

  // per-axis square root and cordic
  logic ax_vld, ay_vld, ax_dg, ay_dg;
  logic [ANGLE_W-1:0] ax_ang, ay_ang;

  fndir_axis #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_axis_x (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (v8_r),
    .in_p     (mx8_r),
    .in_neg   (nx_neg8_r),
    .in_degen (dg8_r),
    .in_sumsq (sumx_r),
    .out_vld  (ax_vld),
    .out_angle(ax_ang),
    .out_degen(ax_dg)
  );

  fndir_axis #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_axis_y (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (v8_r),
    .in_p     (my8_r),
    .in_neg   (ny_neg8_r),
    .in_degen (dg8_r),
    .in_sumsq (sumy_r),
    .out_vld  (ay_vld),
    .out_angle(ay_ang),
    .out_degen(ay_dg)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= ax_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_ax_r    <= ax_ang;
      out_ay_r    <= ay_ang;
      out_degen_r <= ax_dg;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.angle_from_x = out_ax_r;
  assign out_ch.angle_from_y = out_ay_r;
  assign out_ch.degenerate   = out_degen_r;

  // checks
  `ASSERT_CLK(a_lanes_aligned, (ax_vld == ay_vld), "axis pipelines out of step")
  `ASSERT_CLK(a_degen_agree, (ax_vld |-> (ax_dg == ay_dg)), "axis degenerate flags differ")
  `ASSERT_CLK(a_degen_zero, ((out_valid_r && out_degen_r) |->
    (out_ax_r == '0 && out_ay_r == '0)), "degenerate result with non-zero angle")
  `ASSERT_CLK(a_stall_cause, (!en |-> (out_valid_r && !out_ch.ready)),
    "pipeline held without a waiting result")

endmodule
